// ----- rtl/core/sstp_pkg.sv -----
package sstp_pkg;

    localparam int MAX_TEXT_CHARS  = 9;
    localparam int DIGIT_POSITIONS = 4;

    localparam int CHAR_W = 8;
    localparam int SEG_W  = 8;
    localparam int BUF_AW = (MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1;
    localparam int LEN_W  = $clog2(MAX_TEXT_CHARS + 2);
    localparam int POS_W  = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;

    localparam logic [SEG_W-1:0]  DOT_BIT    = 8'h08;
    localparam logic [SEG_W-1:0]  DASH_BIT   = 8'h80;
    localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;

    typedef enum logic [2:0] {
        CK_DIGIT,
        CK_DASH,
        CK_SPACE,
        CK_DOT,
        CK_COLON,
        CK_BAD
    } char_kind_t;

    typedef struct packed {
        char_kind_t        kind;
        logic [SEG_W-1:0]  pattern;
    } char_class_t;

    function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 8'h77;
            4'd1:    p = 8'h14;
            4'd2:    p = 8'hb3;
            4'd3:    p = 8'hb6;
            4'd4:    p = 8'hd4;
            4'd5:    p = 8'he6;
            4'd6:    p = 8'he7;
            4'd7:    p = 8'h34;
            4'd8:    p = 8'hf7;
            4'd9:    p = 8'hf6;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/sstp_if.sv -----
interface sstp_char_if;
    import sstp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface sstp_disp_if;
    import sstp_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments_left;
    logic [SEG_W-1:0] segments_mid_left;
    logic [SEG_W-1:0] segments_mid_right;
    logic [SEG_W-1:0] segments_right;
    logic             colon_lit;
    logic             syntax_error;

    modport source (output valid, output segments_left, output segments_mid_left,
                    output segments_mid_right, output segments_right,
                    output colon_lit, output syntax_error, input ready);
    modport sink   (input valid, input segments_left, input segments_mid_left,
                    input segments_mid_right, input segments_right,
                    input colon_lit, input syntax_error, output ready);
endinterface

// ----- rtl/core/seven_segment_text_parser_top.sv -----
// A non-terminating character produces no result.
// A terminator starts a walk back over the buffered characters (at most 9, fewer once four
// positions fill or a bad character is met; none for an empty or too long string): one
// buffer read per character, then the result is registered.
// Input is held off until the result is loaded into the output register, which lets the next string load.
// Reset (async, active low) clears length, display, colon and handshake state.
module seven_segment_text_parser_top
    import sstp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    sstp_char_if.sink          text,
    sstp_disp_if.source        display
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   cnt_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [SEG_W-1:0]   seg_work_reg [DIGIT_POSITIONS];
    logic               colon_work_reg;
    logic [SEG_W-1:0]   shown_seg_reg [DIGIT_POSITIONS];
    logic               shown_colon_reg;
    logic               err_reg;

    logic               out_valid_reg;
    logic [SEG_W-1:0]   out_seg_reg [4];
    logic               out_colon_reg;
    logic               out_err_reg;

    logic [CHAR_W-1:0]  buf_mem [MAX_TEXT_CHARS];
    logic [CHAR_W-1:0]  rd_data_reg;
    logic [LEN_W-1:0]   rd_addr;
    logic               rd_en;
    logic               wr_en;

    logic               in_fire;
    logic               out_free;
    char_class_t        cls;
    logic [SEG_W-1:0]   seg_next;
    logic               colon_next;
    logic               move;
    logic               bad;
    logic               walk_last;

    assign text.ready = (state_reg == ST_IDLE);
    assign in_fire    = text.valid && text.ready;
    assign out_free   = !out_valid_reg || display.ready;
    assign wr_en      = in_fire && (text.character != CHAR_END)
                        && (len_reg < LEN_W'(MAX_TEXT_CHARS));

    // Next buffer address: last character on the terminator, then walk back.
    always_comb
    begin
        rd_addr = '0;
        rd_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = len_reg - LEN_W'(1);
                rd_en   = (len_reg != '0) && (len_reg <= LEN_W'(MAX_TEXT_CHARS));
            end
            ST_WALK:
            begin
                rd_addr = cnt_reg - LEN_W'(1);
                rd_en   = (cnt_reg != '0);
            end
            default:
            begin
                rd_addr = '0;
                rd_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[len_reg[BUF_AW-1:0]] <= text.character;
        end
        if (rd_en)
        begin
            rd_data_reg <= buf_mem[rd_addr[BUF_AW-1:0]];
        end
    end

    sstp_classify u_classify (
        .character (rd_data_reg),
        .cls       (cls)
    );

    always_comb
    begin
        seg_next   = seg_work_reg[pos_reg];
        colon_next = colon_work_reg;
        move       = 1'b0;
        bad        = 1'b0;
        unique case (cls.kind)
            CK_DIGIT:
            begin
                seg_next = seg_work_reg[pos_reg] | cls.pattern;
                move     = 1'b1;
            end
            CK_DASH:
            begin
                seg_next = seg_work_reg[pos_reg] | DASH_BIT;
                move     = 1'b1;
            end
            CK_SPACE:
            begin
                seg_next = '0;
                move     = 1'b1;
            end
            CK_DOT:
            begin
                seg_next = seg_work_reg[pos_reg] | DOT_BIT;
            end
            CK_COLON:
            begin
                colon_next = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // Stop once the leftmost position is filled or the buffer is used up.
    assign walk_last = (move && (pos_reg == '0)) || (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (in_fire && (text.character == CHAR_END))
        begin
            for (int k = 0; k < DIGIT_POSITIONS; k++)
            begin
                seg_work_reg[k] <= '0;
            end
            colon_work_reg <= 1'b0;
            pos_reg        <= POS_W'(DIGIT_POSITIONS - 1);
            cnt_reg        <= len_reg - LEN_W'(1);
        end
        else if (state_reg == ST_WALK)
        begin
            seg_work_reg[pos_reg] <= seg_next;
            colon_work_reg        <= colon_next;
            if (move)
            begin
                pos_reg <= pos_reg - POS_W'(1);
            end
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (DIGIT_POSITIONS - 4 + k >= 0)
                begin
                    out_seg_reg[k] <= shown_seg_reg[DIGIT_POSITIONS - 4 + k];
                end
                else
                begin
                    out_seg_reg[k] <= '0;
                end
            end
            out_colon_reg <= shown_colon_reg;
            out_err_reg   <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            len_reg         <= '0;
            err_reg         <= 1'b0;
            shown_colon_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < DIGIT_POSITIONS; k++)
            begin
                shown_seg_reg[k] <= '0;
            end
        end
        else
        begin
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (display.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (text.character != CHAR_END)
                        begin
                            if (len_reg < LEN_W'(MAX_TEXT_CHARS))
                            begin
                                len_reg <= len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                len_reg <= LEN_W'(MAX_TEXT_CHARS + 1);
                            end
                        end
                        else
                        begin
                            len_reg <= '0;
                            priority if (len_reg > LEN_W'(MAX_TEXT_CHARS))
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_FINISH;
                            end
                            else if (len_reg == '0)
                            begin
                                // empty string: blank the display
                                for (int k = 0; k < DIGIT_POSITIONS; k++)
                                begin
                                    shown_seg_reg[k] <= '0;
                                end
                                shown_colon_reg <= 1'b0;
                                err_reg         <= 1'b0;
                                state_reg       <= ST_FINISH;
                            end
                            else
                            begin
                                state_reg <= ST_WALK;
                            end
                        end
                    end
                end
                ST_WALK:
                begin
                    if (bad)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (walk_last)
                    begin
                        for (int k = 0; k < DIGIT_POSITIONS; k++)
                        begin
                            shown_seg_reg[k] <= (k == int'(pos_reg)) ? seg_next
                                                                     : seg_work_reg[k];
                        end
                        shown_colon_reg <= colon_next;
                        err_reg         <= 1'b0;
                        state_reg       <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign display.valid              = out_valid_reg;
    assign display.segments_left      = out_seg_reg[0];
    assign display.segments_mid_left  = out_seg_reg[1];
    assign display.segments_mid_right = out_seg_reg[2];
    assign display.segments_right     = out_seg_reg[3];
    assign display.colon_lit          = out_colon_reg;
    assign display.syntax_error       = out_err_reg;

endmodule

// ----- rtl/core/sstp_classify.sv -----
module sstp_classify
    import sstp_pkg::*;
(
    input  logic [CHAR_W-1:0] character,
    output char_class_t       cls
);

    logic [CHAR_W-1:0] offset;

    assign offset = character - CHAR_ZERO;

    always_comb
    begin
        cls.pattern = 8'h00;
        priority if (character >= CHAR_ZERO && character <= CHAR_NINE)
        begin
            cls.kind    = CK_DIGIT;
            cls.pattern = digit_pattern(offset[3:0]);
        end
        else if (character == CHAR_DASH)
        begin
            cls.kind = CK_DASH;
        end
        else if (character == CHAR_SPACE)
        begin
            cls.kind = CK_SPACE;
        end
        else if (character == CHAR_DOT)
        begin
            cls.kind = CK_DOT;
        end
        else if (character == CHAR_COLON)
        begin
            cls.kind = CK_COLON;
        end
        else
        begin
            cls.kind = CK_BAD;
        end
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import sstp_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        bit                drain;
    } text_item_t;

    typedef struct {
        logic [SEG_W-1:0] left;
        logic [SEG_W-1:0] mid_left;
        logic [SEG_W-1:0] mid_right;
        logic [SEG_W-1:0] right;
        logic             colon;
        logic             error;
    } disp_t;

    localparam logic [SEG_W-1:0] SEG_FONT [10] = '{
        8'h77, 8'h14, 8'hb3, 8'hb6, 8'hd4, 8'he6, 8'he7, 8'h34, 8'hf7, 8'hf6
    };

    logic clk;
    logic rst_n;

    sstp_char_if text_ch ();
    sstp_disp_if disp_ch ();

    seven_segment_text_parser_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .display (disp_ch)
    );

    text_item_t  pending_chars [$];
    disp_t       expected_displays [$];
    int          n_items = 0;
    bit          failed = 1'b0;
    logic        text_fired;
    int unsigned tick = 0;
    bit          steady;

    // display state tracked alongside the block
    logic [CHAR_W-1:0] txt_buf [MAX_TEXT_CHARS];
    int                txt_len = 0;
    logic [SEG_W-1:0]  shown_seg [DIGIT_POSITIONS];
    logic              shown_colon = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_display_state();
        txt_len = 0;
        shown_colon = 1'b0;
        for (int k = 0; k < DIGIT_POSITIONS; k++)
        begin
            shown_seg[k] = '0;
        end
    endtask

    task automatic absorb_character(input logic [CHAR_W-1:0] ch);
        logic [SEG_W-1:0]  seg [DIGIT_POSITIONS];
        logic [SEG_W-1:0]  quad [4];
        logic [CHAR_W-1:0] c;
        logic              colon;
        logic              bad;
        int                pos;
        int                n;
        disp_t             d;

        if (ch != CHAR_END)
        begin
            if (txt_len < MAX_TEXT_CHARS)
            begin
                txt_buf[txt_len] = ch;
                txt_len++;
            end
            else
            begin
                txt_len = MAX_TEXT_CHARS + 1;
            end
            return;
        end

        bad = (txt_len > MAX_TEXT_CHARS);
        colon = 1'b0;
        pos = DIGIT_POSITIONS - 1;
        n = txt_len;
        for (int k = 0; k < DIGIT_POSITIONS; k++)
        begin
            seg[k] = '0;
        end
        // walk back from the last character, filling right to left
        while (!bad && n > 0 && pos >= 0)
        begin
            n--;
            c = txt_buf[n];
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                seg[pos] = seg[pos] | SEG_FONT[c - CHAR_ZERO];
                pos--;
            end
            else if (c == CHAR_DASH)
            begin
                seg[pos] = seg[pos] | DASH_BIT;
                pos--;
            end
            else if (c == CHAR_COLON)
            begin
                colon = 1'b1;
            end
            else if (c == CHAR_SPACE)
            begin
                seg[pos] = '0;
                pos--;
            end
            else if (c == CHAR_DOT)
            begin
                seg[pos] = seg[pos] | DOT_BIT;
            end
            else
            begin
                bad = 1'b1;
            end
        end
        // keep the old display on any error
        if (!bad)
        begin
            for (int k = 0; k < DIGIT_POSITIONS; k++)
            begin
                shown_seg[k] = seg[k];
            end
            shown_colon = colon;
        end
        txt_len = 0;

        for (int k = 0; k < 4; k++)
        begin
            quad[k] = (DIGIT_POSITIONS - 4 + k >= 0) ? shown_seg[DIGIT_POSITIONS - 4 + k] : '0;
        end
        d.left      = quad[0];
        d.mid_left  = quad[1];
        d.mid_right = quad[2];
        d.right     = quad[3];
        d.colon     = shown_colon;
        d.error     = bad;
        expected_displays.push_back(d);
    endtask

    task automatic compare_field(input string what, input logic [SEG_W-1:0] want,
                                 input logic [SEG_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %02h, actual %02h", $time, what, want, got);
            failed = 1'b1;
        end
    endtask

    // monitor: predict on accepted characters, check accepted displays
    always @(posedge clk or negedge rst_n)
    begin : monitor
        disp_t want;

        if (!rst_n)
        begin
            text_fired <= 1'b0;
            clear_display_state();
        end
        else
        begin
            text_fired <= text_ch.valid && text_ch.ready;
            if (text_ch.valid && text_ch.ready)
            begin
                absorb_character(text_ch.character);
            end
            if (disp_ch.valid && disp_ch.ready)
            begin
                if (expected_displays.size() == 0)
                begin
                    $display("%0t: extra display item, expected none, actual %h %h %h %h %b %b",
                             $time, disp_ch.segments_left, disp_ch.segments_mid_left,
                             disp_ch.segments_mid_right, disp_ch.segments_right,
                             disp_ch.colon_lit, disp_ch.syntax_error);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_displays.pop_front();
                    compare_field("segments_left", want.left, disp_ch.segments_left);
                    compare_field("segments_mid_left", want.mid_left, disp_ch.segments_mid_left);
                    compare_field("segments_mid_right", want.mid_right,
                                  disp_ch.segments_mid_right);
                    compare_field("segments_right", want.right, disp_ch.segments_right);
                    compare_field("colon_lit", SEG_W'(want.colon), SEG_W'(disp_ch.colon_lit));
                    compare_field("syntax_error", SEG_W'(want.error),
                                  SEG_W'(disp_ch.syntax_error));
                end
            end
        end
    end

    assign steady = (tick >= 1500 && tick < 3000);

    // driver: present characters and the display ready at the falling edge
    always @(negedge clk)
    begin
        tick++;
        if (!rst_n)
        begin
            text_ch.valid <= 1'b0;
            disp_ch.ready <= 1'b0;
        end
        else
        begin
            disp_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
            if (!text_ch.valid || text_fired)
            begin
                if (pending_chars.size() == 0
                    || (pending_chars[0].drain && expected_displays.size() != 0)
                    || (!steady && $urandom_range(0, 99) < 20))
                begin
                    text_ch.valid <= 1'b0;
                end
                else
                begin
                    text_ch.valid <= 1'b1;
                    text_ch.character <= pending_chars[0].ch;
                    void'(pending_chars.pop_front());
                end
            end
        end
    end

    task automatic queue_char(input logic [CHAR_W-1:0] ch, input bit drain = 1'b0);
        text_item_t it;

        it.ch = ch;
        it.drain = drain;
        pending_chars.push_back(it);
        n_items++;
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            queue_char(s[k]);
        end
        queue_char(CHAR_END);
    endtask

    function automatic logic [CHAR_W-1:0] display_char();
        int r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
        else if (r < 65)
            return CHAR_DASH;
        else if (r < 75)
            return CHAR_SPACE;
        else if (r < 88)
            return CHAR_DOT;
        return CHAR_COLON;
    endfunction

    initial
    begin
        int                mode;
        int                len;
        int                bad_at;
        bit                drained;
        logic [CHAR_W-1:0] ch;

        clk = 1'b0;
        rst_n = 1'b0;
        text_ch.valid = 1'b0;
        text_ch.character = '0;
        disp_ch.ready = 1'b0;
        drained = 1'b0;

        // empty string, every operation, ignored junk on the left,
        // a rejected character, a string one too long
        queue_text("");
        queue_text("9.:-0 ");
        queue_char(8'hff);
        queue_text("1234");
        queue_text("1a");
        queue_text("0123456789");

        while (n_items < 1300)
        begin
            if (!drained && n_items >= 650)
            begin
                queue_char(CHAR_END, 1'b1);
                drained = 1'b1;
            end
            mode = $urandom_range(0, 99);
            if (mode < 70)
                len = $urandom_range(0, MAX_TEXT_CHARS);
            else if (mode < 80)
                len = $urandom_range(MAX_TEXT_CHARS + 1, 15);
            else
                len = $urandom_range(1, MAX_TEXT_CHARS);
            bad_at = (mode >= 80 && mode < 90) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++)
            begin
                if (mode >= 90)
                begin
                    ch = CHAR_W'($urandom_range(1, 255));
                end
                else if (k == bad_at)
                begin
                    do
                        ch = CHAR_W'($urandom_range(1, 255));
                    while (ch inside {[CHAR_ZERO:CHAR_NINE], CHAR_DASH, CHAR_SPACE,
                                      CHAR_DOT, CHAR_COLON});
                end
                else
                begin
                    ch = display_char();
                end
                queue_char(ch);
            end
            queue_char(CHAR_END);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_chars.size() == 0 && !text_ch.valid);
        wait (expected_displays.size() == 0);
        repeat (30) @(posedge clk);
        if (!failed)
            $display("[seven_segment_text_parser_top] OK");
        else
            $display("[seven_segment_text_parser_top] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[seven_segment_text_parser_top] ERROR");
        $finish;
    end

endmodule
